### hdl/sptt_pkg.sv
// Shared types and constants for the sorted-pair translation table.
// Used by sptt_step and sorted_pair_table_translate; no dependencies.
package sptt_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH_DEFAULT = 16384;
   localparam int CODE_W              = 16;
   localparam int INDEX_W             = 14;
   localparam int COUNT_W             = 15;
   localparam int ENTRY_W             = 2 * CODE_W;

   // Search bounds are signed: the upper bound can drop to -1.
   localparam int SEARCH_W = COUNT_W + 3;

   localparam logic signed [SEARCH_W-1:0] ONE_S  = SEARCH_W'(1);
   localparam logic signed [SEARCH_W-1:0] ZERO_S = '0;

   localparam logic [CODE_W-1:0] NOT_FOUND_CODE = '0;

   // Request type codes.
   localparam logic REQ_LOAD      = 1'b0;
   localparam logic REQ_TRANSLATE = 1'b1;

   // Result of one search step.
   typedef struct packed {
      logic signed [SEARCH_W-1:0] lo;
      logic signed [SEARCH_W-1:0] hi;
      logic signed [SEARCH_W-1:0] mid;
      logic                       eq;
      logic                       more;
   } step_type;

endpackage

### hdl/sptt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sptt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hdl/sptt_step.sv
// One binary-search step: compare the probed source code and narrow the bounds.
// Depends on sptt_pkg.
module sptt_step (
   input  logic signed [sptt_pkg::SEARCH_W-1:0] lo,
   input  logic signed [sptt_pkg::SEARCH_W-1:0] hi,
   input  logic signed [sptt_pkg::SEARCH_W-1:0] mid,
   input  logic        [sptt_pkg::CODE_W-1:0]   code,
   input  logic        [sptt_pkg::CODE_W-1:0]   probe,
   output sptt_pkg::step_type                   step
);

   logic                                ge;
   logic                                le;
   logic signed [sptt_pkg::SEARCH_W-1:0] lo_n;
   logic signed [sptt_pkg::SEARCH_W-1:0] hi_n;
   logic signed [sptt_pkg::SEARCH_W-1:0] sum_n;

   always_comb begin
      ge    = code >= probe;
      le    = code <= probe;
      lo_n  = ge ? mid + sptt_pkg::ONE_S : lo;
      hi_n  = le ? mid - sptt_pkg::ONE_S : hi;
      sum_n = lo_n + hi_n;

      step.lo   = lo_n;
      step.hi   = hi_n;
      // Bounds are non-negative whenever another probe follows.
      step.mid  = sum_n >>> 1;
      step.eq   = ge && le;
      step.more = lo_n <= hi_n;
   end

endmodule

### hdl/sorted_pair_table_translate.sv
// Top level of the sorted-pair code translation table.
// Depends on sptt_pkg, sptt_ram and sptt_step.

// A load item (req_type = 0) writes one (source, destination) pair into the table and
// gives no result; loads at an index at or above TABLE_DEPTH are dropped.
// A translate item (req_type = 1) binary-searches the first csr_entry_count entries,
// which software must have loaded in ascending source order, and returns the paired
// destination with rsp_found set, or 0 with rsp_found clear. One item is in work at a
// time: req_stall stays high from acceptance until the result sits in the output
// register. A character equal to the last one translated is served from a one-entry
// memo. A search issues its first read on acceptance, then compares one table probe
// per cycle (at most ceil(log2(n + 1)) probes for n searched entries, 15 for a full
// 16384-entry table), then hands the result to the output register; the single read
// port of the table RAM, probed once per cycle by the shared step unit, sets the
// pace of the probes. The output register lets the next item enter while a result
// still waits on rsp_stall. Any load into the table and any write of csr_entry_count
// empty the memo. An entry count of 0 always reports missing; a count above TABLE_DEPTH
// searches TABLE_DEPTH entries. Write csr_entry_count only while the block is idle.
module sorted_pair_table_translate #(
   parameter int TABLE_DEPTH = sptt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_type,
   input  logic [sptt_pkg::INDEX_W-1:0]   req_entry_index,
   input  logic [sptt_pkg::CODE_W-1:0]    req_entry_source,
   input  logic [sptt_pkg::CODE_W-1:0]    req_entry_dest,
   input  logic [sptt_pkg::CODE_W-1:0]    req_char_code,
   // Response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [sptt_pkg::CODE_W-1:0]    rsp_translated_code,
   output logic                           rsp_found,
   // Register write channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sptt_pkg::COUNT_W-1:0]   csr_entry_count
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int SW     = sptt_pkg::SEARCH_W;
   localparam int CW     = sptt_pkg::CODE_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_PROBE,
      S_FINISH
   } state_type;

   // Sequencer and search registers
   state_type                      state_ff, state_in;
   logic signed [SW-1:0]           lo_ff, lo_in;
   logic signed [SW-1:0]           hi_ff, hi_in;
   logic signed [SW-1:0]           mid_ff, mid_in;
   logic [CW-1:0]                  code_ff, code_in;
   logic [CW-1:0]                  res_ff, res_in;
   logic                           hit_ff, hit_in;

   // Configuration and memo
   logic [sptt_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic [CW-1:0]                  memo_char_ff, memo_char_in;
   logic [CW-1:0]                  memo_res_ff, memo_res_in;
   logic                           memo_hit_ff, memo_hit_in;
   logic                           memo_valid_ff, memo_valid_in;

   // Output register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]                  rsp_code_ff, rsp_code_in;
   logic                           rsp_found_ff, rsp_found_in;

   // Combinational helpers
   logic                           req_fire;
   logic                           csr_fire;
   logic                           load_ok;
   logic                           out_free;
   logic [SW-1:0]                  n_clamp;
   logic [SW-1:0]                  first_mid;
   logic                           ram_we;
   logic [ADDR_W-1:0]              ram_waddr;
   logic [ADDR_W-1:0]              ram_raddr;
   logic [sptt_pkg::ENTRY_W-1:0]   ram_rdata;
   logic [CW-1:0]                  probe_src;
   logic [CW-1:0]                  probe_dst;
   sptt_pkg::step_type             step;

   assign req_stall = state_ff != S_IDLE;
   assign csr_ready = state_ff == S_IDLE;
   assign req_fire  = req_valid && !req_stall;
   assign csr_fire  = csr_valid && csr_ready;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load_ok   = 32'(req_entry_index) < 32'(TABLE_DEPTH);

   // Clamp the searched range to the table.
   assign n_clamp   = (SW'(count_ff) > SW'(TABLE_DEPTH)) ? SW'(TABLE_DEPTH) : SW'(count_ff);
   assign first_mid = (n_clamp - SW'(1)) >> 1;

   // Table: source code in the upper half of a word, destination in the lower.
   assign ram_we    = req_fire && (req_type == sptt_pkg::REQ_LOAD) && load_ok;
   assign ram_waddr = ADDR_W'(req_entry_index);
   // Probe the midpoint chosen by the step unit while probing, or the first midpoint otherwise.
   assign ram_raddr = (state_ff == S_PROBE) ? step.mid[ADDR_W-1:0] : first_mid[ADDR_W-1:0];
   assign probe_src = ram_rdata[sptt_pkg::ENTRY_W-1:CW];
   assign probe_dst = ram_rdata[CW-1:0];

   sptt_ram #(
      .WIDTH (sptt_pkg::ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata ({req_entry_source, req_entry_dest}),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   sptt_step u_step (
      .lo    (lo_ff),
      .hi    (hi_ff),
      .mid   (mid_ff),
      .code  (code_ff),
      .probe (probe_src),
      .step  (step)
   );

   always_comb begin
      state_in      = state_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      code_in       = code_ff;
      res_in        = res_ff;
      hit_in        = hit_ff;
      count_in      = count_ff;
      memo_char_in  = memo_char_ff;
      memo_res_in   = memo_res_ff;
      memo_hit_in   = memo_hit_ff;
      memo_valid_in = memo_valid_ff;
      // Drop the pending result once the consumer takes it.
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_code_in   = rsp_code_ff;
      rsp_found_in  = rsp_found_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_type == sptt_pkg::REQ_TRANSLATE)) begin
               code_in = req_char_code;
               priority if (memo_valid_ff && (memo_char_ff == req_char_code)) begin
                  // Repeated character: answer from the memo.
                  res_in   = memo_res_ff;
                  hit_in   = memo_hit_ff;
                  state_in = S_FINISH;
               end else if (n_clamp == '0) begin
                  // Empty table: report missing without a probe.
                  res_in        = sptt_pkg::NOT_FOUND_CODE;
                  hit_in        = 1'b0;
                  memo_char_in  = req_char_code;
                  memo_res_in   = sptt_pkg::NOT_FOUND_CODE;
                  memo_hit_in   = 1'b0;
                  memo_valid_in = 1'b1;
                  state_in      = S_FINISH;
               end else begin
                  // First probe is issued at the midpoint this cycle.
                  lo_in    = sptt_pkg::ZERO_S;
                  hi_in    = signed'(n_clamp) - sptt_pkg::ONE_S;
                  mid_in   = signed'(first_mid);
                  state_in = S_PROBE;
               end
            end
         end

         S_PROBE: begin
            if (step.eq || !step.more) begin
               // Match ends the search at once; otherwise the bounds crossed.
               res_in        = step.eq ? probe_dst : sptt_pkg::NOT_FOUND_CODE;
               hit_in        = step.eq;
               memo_char_in  = code_ff;
               memo_res_in   = step.eq ? probe_dst : sptt_pkg::NOT_FOUND_CODE;
               memo_hit_in   = step.eq;
               memo_valid_in = 1'b1;
               state_in      = S_FINISH;
            end else begin
               // Advance: next read already issued at step.mid.
               lo_in  = step.lo;
               hi_in  = step.hi;
               mid_in = step.mid;
            end
         end

         S_FINISH: begin
            // Hold the result until the output register is free.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = res_ff;
               rsp_found_in = hit_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Any table write or count write empties the memo.
      if (ram_we) begin
         memo_valid_in = 1'b0;
      end
      if (csr_fire) begin
         count_in      = csr_entry_count;
         memo_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         memo_char_ff  <= '0;
         memo_res_ff   <= '0;
         memo_hit_ff   <= 1'b0;
         memo_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         memo_char_ff  <= memo_char_in;
         memo_res_ff   <= memo_res_in;
         memo_hit_ff   <= memo_hit_in;
         memo_valid_ff <= memo_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      code_ff      <= code_in;
      res_ff       <= res_in;
      hit_ff       <= hit_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_translated_code = rsp_code_ff;
   assign rsp_found           = rsp_found_ff;

`ifndef NO_ASSERTIONS
   // A missing character always carries a zero code.
   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_translated_code == sptt_pkg::NOT_FOUND_CODE)
      else $error("missing result carries a nonzero code");

   // A table load empties the memo.
   a_load_clears_memo: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> !memo_valid_ff)
      else $error("memo survived a table load");

   // While probing, the bounds stay ordered and inside the searched range.
   a_probe_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PROBE |->
         lo_ff <= hi_ff && lo_ff >= sptt_pkg::ZERO_S && hi_ff < signed'(n_clamp))
      else $error("search bounds out of range");
`endif

endmodule
